### src/tlst_pkg.sv
// ----------------------------------------------------------------------------
// tlst_pkg
// Shared widths, state and opcode codes and the table control struct for the
// track lifecycle state table.
// ----------------------------------------------------------------------------
package tlst_pkg;

    localparam int ST_W     = 2;
    localparam int ID_W     = 6;
    localparam int POS_W    = 12;
    localparam int TIME_W   = 63;
    // a 6-bit identifier can only reach this many table entries
    localparam int ID_LIMIT = 64;

    typedef logic [ST_W-1:0] t_st;

    localparam t_st ST_DETECT = 2'd0;
    localparam t_st ST_TRACK  = 2'd1;
    localparam t_st ST_LOST   = 2'd2;
    localparam t_st ST_NONE   = 2'd3;

    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

endpackage

### src/tlst_table.sv
// ----------------------------------------------------------------------------
// tlst_table
// Per-ID table memory: one write port, one read port with a registered read
// and a valid bit per entry so that an unwritten entry reads as "none".
// ----------------------------------------------------------------------------
module tlst_table
    import tlst_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_ctl      i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data,
    output logic          o_rd_valid
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

### src/track_lifecycle_state_table_core.sv
// ----------------------------------------------------------------------------
// track_lifecycle_state_table_core
// Per-ID track lifecycle table: detections are classed DETECT or TRACK
// against the previous frame, end of frame reports LOST IDs and rolls over.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   opcode, id, x, y, time
//   output   out        o_out_valid / i_out_stall state, id, x, y, time, last
//
// A detection reads the entry of an in-range ID on the accepting edge; S_DET
// writes it back and loads the output register once that register is free.
// End of frame reads, checks and rewrites one of min(ID_COUNT, 64) table entries
// per cycle through the single read port; a second lost ID waits for the output.
// Output stalls add cycles only when a result is ready and the register is full.
// Reset clears the per-entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module track_lifecycle_state_table_core
    import tlst_pkg::*;
#(
    parameter int ID_COUNT   = 64,
    parameter int COORD_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_tracking_id,
    input  logic [POS_W-1:0]  i_pos_x,
    input  logic [POS_W-1:0]  i_pos_y,
    input  logic [TIME_W-1:0] i_time_us,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ST_W-1:0]   o_track_state,
    output logic [ID_W-1:0]   o_out_id,
    output logic [POS_W-1:0]  o_out_x,
    output logic [POS_W-1:0]  o_out_y,
    output logic [TIME_W-1:0] o_out_time_us,
    output logic              o_last_of_run
);

    localparam int LIM   = (ID_COUNT < ID_LIMIT) ? ID_COUNT : ID_LIMIT;
    localparam int AW    = $clog2(LIM);
    localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int DW    = 2 * ST_W + 2 * CW;
    localparam int CMP_W = ID_W + 3;
    localparam logic [AW-1:0]    LAST_IDX = AW'(LIM - 1);
    localparam logic [CMP_W-1:0] ID_CNT_V = CMP_W'(ID_COUNT);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DET     = 2'd1;
    localparam logic [1:0] S_SWP_EV  = 2'd2;
    localparam logic [1:0] S_SWP_END = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ID_W-1:0]   r_id;
    logic [CW-1:0]     r_x, r_y;
    logic [TIME_W-1:0] r_time;
    logic              r_in_rng;
    logic [AW-1:0]     r_idx, n_idx;

    logic              r_pend_vld;
    logic [AW-1:0]     r_pend_id;
    logic [CW-1:0]     r_pend_x, r_pend_y;

    logic              r_out_vld;
    t_st               r_out_st;
    logic [ID_W-1:0]   r_out_id;
    logic [POS_W-1:0]  r_out_x, r_out_y;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_last;

    t_tbl_ctl          tbl_ctl;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [DW-1:0]     wr_data, rd_data;
    logic              rd_valid;

    t_st               rd_prev, rd_cur, det_st;
    logic [CW-1:0]     rd_x, rd_y;
    logic              in_acc, in_rng, out_free, lost, sweep_go;
    logic              out_load, pend_load, pend_clr;
    t_st               ld_st;
    logic [ID_W-1:0]   ld_id;
    logic [POS_W-1:0]  ld_x, ld_y;
    logic              ld_last;

    tlst_table #(
        .DEPTH (LIM),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_rng     = ({3'b000, i_tracking_id} < ID_CNT_V);
    assign out_free   = !r_out_vld || !i_out_stall;

    // an entry never written reads as none in both frames
    assign rd_prev = rd_valid ? rd_data[DW-1 -: ST_W] : ST_NONE;
    assign rd_cur  = rd_valid ? rd_data[DW-ST_W-1 -: ST_W] : ST_NONE;
    assign rd_x    = rd_data[2*CW-1 -: CW];
    assign rd_y    = rd_data[CW-1:0];

    assign det_st  = (r_in_rng && (rd_prev == ST_DETECT || rd_prev == ST_TRACK))
                     ? ST_TRACK : ST_DETECT;
    assign lost    = (rd_prev == ST_DETECT || rd_prev == ST_TRACK) && (rd_cur == ST_NONE);
    // a second lost ID must first push the held one out
    assign sweep_go = !(lost && r_pend_vld && !out_free);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        tbl_ctl   = '0;
        rd_addr   = r_idx + AW'(1);
        wr_addr   = r_idx;
        wr_data   = {rd_cur, ST_NONE, rd_x, rd_y};
        out_load  = 1'b0;
        pend_load = 1'b0;
        pend_clr  = 1'b0;
        ld_st     = ST_LOST;
        ld_id     = ID_W'(r_pend_id);
        ld_x      = POS_W'(r_pend_x);
        ld_y      = POS_W'(r_pend_y);
        ld_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_EOF) begin
                        tbl_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        n_idx         = '0;
                        n_state       = S_SWP_EV;
                    end else begin
                        tbl_ctl.rd_en = in_rng;
                        rd_addr       = i_tracking_id[AW-1:0];
                        n_state       = S_DET;
                    end
                end
            end
            S_DET: begin
                wr_addr = r_id[AW-1:0];
                wr_data = {rd_prev, det_st, r_x, r_y};
                ld_st   = det_st;
                ld_id   = r_id;
                ld_x    = POS_W'(r_x);
                ld_y    = POS_W'(r_y);
                ld_last = 1'b1;
                if (out_free) begin
                    tbl_ctl.wr_en = r_in_rng;
                    out_load      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SWP_EV: begin
                if (sweep_go) begin
                    // roll the entry over: this frame becomes previous
                    tbl_ctl.wr_en = 1'b1;
                    wr_data = {(lost ? ST_LOST : rd_cur), ST_NONE, rd_x, rd_y};
                    out_load  = lost && r_pend_vld;
                    pend_load = lost;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_SWP_END;
                    end else begin
                        tbl_ctl.rd_en = 1'b1;
                        n_idx         = r_idx + AW'(1);
                    end
                end
            end
            S_SWP_END: begin
                ld_last = 1'b1;
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    pend_clr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (pend_load) begin
                r_pend_vld <= 1'b1;
            end else if (pend_clr) begin
                r_pend_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id     <= i_tracking_id;
            r_x      <= i_pos_x[CW-1:0];
            r_y      <= i_pos_y[CW-1:0];
            r_time   <= i_time_us;
            r_in_rng <= in_rng;
        end
        if (pend_load) begin
            r_pend_id <= r_idx;
            r_pend_x  <= rd_x;
            r_pend_y  <= rd_y;
        end
        if (out_load) begin
            r_out_st   <= ld_st;
            r_out_id   <= ld_id;
            r_out_x    <= ld_x;
            r_out_y    <= ld_y;
            r_out_time <= r_time;
            r_out_last <= ld_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_track_state = r_out_st;
    assign o_out_id      = r_out_id;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_time_us = r_out_time;
    assign o_last_of_run = r_out_last;

    a_pend_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == S_SWP_EV || r_state == S_SWP_END))
        else $error("held lost item outside the sweep");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_ctl.rd_en && tbl_ctl.wr_en) |-> (rd_addr != wr_addr))
        else $error("table read and write hit the same entry");

    a_det_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DET && out_load) |=> (o_out_valid && o_last_of_run))
        else $error("detection result not marked last");

    a_no_none_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_track_state != ST_NONE))
        else $error("result carries state none");

    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_ctl.wr_en |-> (r_state == S_DET || r_state == S_SWP_EV))
        else $error("table written outside a read-modify-write step");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for track_lifecycle_state_table_core. A small tracker
// class mirrors the per-ID lifecycle table and queues the results each
// accepted item should give; every result taken from the block is compared
// field by field against the oldest one. Directed frames cover the ID, position
// and timestamp extremes, track promotion, loss and ageing, repeated IDs and
// quiet frames, then random frames with random gaps and output stalls follow,
// including one full table that is lost in a single sweep.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlst_pkg::*;

    localparam int ID_COUNT       = 64;
    localparam int COORD_BITS     = 12;
    localparam int SWEEP_IDS      = (ID_COUNT < ID_LIMIT) ? ID_COUNT : ID_LIMIT;
    localparam int RANDOM_ITEMS   = 90;
    localparam int CALM_ITEMS     = 12;
    localparam int TAIL_CYCLES    = 2 * (SWEEP_IDS + 4);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [POS_W-1:0] COORD_MASK = POS_W'((64'd1 << COORD_BITS) - 64'd1);

    typedef struct {
        t_st               st;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } t_lifecycle_result;

    class lifecycle_tracker;
        t_st               prev_st [ID_COUNT];
        t_st               cur_st  [ID_COUNT];
        logic [POS_W-1:0]  last_x  [ID_COUNT];
        logic [POS_W-1:0]  last_y  [ID_COUNT];
        t_lifecycle_result pending_results [$];
        int                n_mismatch;

        function new();
            foreach (prev_st[i]) begin
                prev_st[i] = ST_NONE;
                cur_st[i]  = ST_NONE;
                last_x[i]  = '0;
                last_y[i]  = '0;
            end
            n_mismatch = 0;
        endfunction

        function void note_item(logic op, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                                logic [POS_W-1:0] y, logic [TIME_W-1:0] stamp);
            t_lifecycle_result r;
            int n_lost;
            r.stamp = stamp;
            if (op == OP_DETECT) begin
                r.st   = ST_DETECT;
                r.id   = id;
                r.x    = x & COORD_MASK;
                r.y    = y & COORD_MASK;
                r.last = 1'b1;
                // IDs past the table answer DETECT and leave it alone
                if (id < ID_COUNT) begin
                    if (prev_st[id] == ST_DETECT || prev_st[id] == ST_TRACK) begin
                        r.st = ST_TRACK;
                    end
                    cur_st[id] = r.st;
                    last_x[id] = r.x;
                    last_y[id] = r.y;
                end
                pending_results.push_back(r);
            end else begin
                n_lost = 0;
                for (int i = 0; i < SWEEP_IDS; i++) begin
                    if ((prev_st[i] == ST_DETECT || prev_st[i] == ST_TRACK)
                            && cur_st[i] == ST_NONE) begin
                        r.st   = ST_LOST;
                        r.id   = ID_W'(i);
                        r.x    = last_x[i];
                        r.y    = last_y[i];
                        r.last = 1'b0;
                        pending_results.push_back(r);
                        cur_st[i] = ST_LOST;
                        n_lost++;
                    end
                end
                if (n_lost > 0) begin
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
                // roll the frame over
                prev_st = cur_st;
                foreach (cur_st[i]) begin
                    cur_st[i] = ST_NONE;
                end
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            n_mismatch++;
        endtask

        task check_result(t_st st, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                          logic [POS_W-1:0] y, logic [TIME_W-1:0] stamp, logic last);
            t_lifecycle_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected (state %0d id %0d)", st, id));
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.st)
                report($sformatf("track_state got %0d want %0d (id %0d)", st, want.st, want.id));
            if (id !== want.id)
                report($sformatf("out_id got %0d want %0d", id, want.id));
            if (x !== want.x)
                report($sformatf("out_x got 0x%0h want 0x%0h (id %0d)", x, want.x, want.id));
            if (y !== want.y)
                report($sformatf("out_y got 0x%0h want 0x%0h (id %0d)", y, want.y, want.id));
            if (stamp !== want.stamp)
                report($sformatf("out_time_us got 0x%0h want 0x%0h (id %0d)",
                                 stamp, want.stamp, want.id));
            if (last !== want.last)
                report($sformatf("last_of_run got %0b want %0b (id %0d)",
                                 last, want.last, want.id));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_opcode;
    logic [ID_W-1:0]   i_tracking_id;
    logic [POS_W-1:0]  i_pos_x;
    logic [POS_W-1:0]  i_pos_y;
    logic [TIME_W-1:0] i_time_us;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [ST_W-1:0]   o_track_state;
    logic [ID_W-1:0]   o_out_id;
    logic [POS_W-1:0]  o_out_x;
    logic [POS_W-1:0]  o_out_y;
    logic [TIME_W-1:0] o_out_time_us;
    logic              o_last_of_run;

    lifecycle_tracker tracker = new();
    int  results_due  = 0;
    int  quiet_cycles = 0;
    bit  idle_on      = 1'b1;
    bit  prev_seen [ID_COUNT];
    bit  cur_seen  [ID_COUNT];

    track_lifecycle_state_table_core #(
        .ID_COUNT   (ID_COUNT),
        .COORD_BITS (COORD_BITS)
    ) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // sample both handshakes at the edge they complete on
    always @(posedge i_clk) begin
        bit took;
        took = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            tracker.note_item(i_opcode, i_tracking_id, i_pos_x, i_pos_y, i_time_us);
            took = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_track_state, o_out_id, o_out_x, o_out_y,
                                 o_out_time_us, o_last_of_run);
            took = 1'b1;
        end
        results_due  = tracker.pending_results.size();
        quiet_cycles = took ? 0 : quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[track_lifecycle_state_table_core] ERROR");
        $finish;
    end

    // output side: stall in random bursts while idling is on
    initial begin
        int burst;
        burst = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (burst > 0) begin
                burst--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9);
            end
            i_out_stall <= (burst > 0);
        end
    end

    function automatic logic [TIME_W-1:0] rand_stamp();
        return TIME_W'({$urandom, $urandom});
    endfunction

    task automatic drive_item(logic op, logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                              logic [POS_W-1:0] y, logic [TIME_W-1:0] stamp);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_tracking_id <= id;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_time_us     <= stamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_detection(logic [ID_W-1:0] id);
        drive_item(OP_DETECT, id, POS_W'($urandom), POS_W'($urandom), rand_stamp());
    endtask

    task automatic send_eof();
        drive_item(OP_EOF, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   rand_stamp());
    endtask

    // hold off the sender until every queued result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the last accepted item reach the tracker first
        @(posedge i_clk);
        wait (results_due == 0);
        @(posedge i_clk);
    endtask

    initial begin
        int random_sent;
        int n_det;
        int start;
        int tries;
        bit prefer_prev;
        bit full_done;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] last_id;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_DETECT;
        i_tracking_id <= '0;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_time_us     <= '0;
        foreach (prev_seen[i]) begin
            prev_seen[i] = 1'b0;
            cur_seen[i]  = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // quiet end of frame straight after reset
        drive_item(OP_EOF, '0, '0, '0, '0);
        drive_item(OP_DETECT, 6'd0, 12'h000, 12'h000, '1);
        drive_item(OP_DETECT, 6'd63, 12'hfff, 12'hfff, '0);
        drive_item(OP_DETECT, 6'd5, 12'h07b, 12'hbb8, rand_stamp());
        // repeated ID: recomputed against last frame, position overwritten
        drive_item(OP_DETECT, 6'd5, 12'h007, 12'h009, rand_stamp());
        drive_item(OP_EOF, '1, '1, '1, '1);
        // promote to TRACK, then lose ID 5
        drive_item(OP_DETECT, 6'd0, 12'hfff, 12'h000, rand_stamp());
        drive_item(OP_DETECT, 6'd63, 12'h000, 12'hfff, rand_stamp());
        drive_item(OP_EOF, 6'd21, 12'h555, 12'haaa, rand_stamp());
        // a LOST ID comes back as DETECT
        drive_item(OP_DETECT, 6'd5, 12'h123, 12'h456, rand_stamp());
        drive_item(OP_DETECT, 6'd0, 12'h800, 12'h001, rand_stamp());
        drive_item(OP_DETECT, 6'd0, 12'h001, 12'h800, rand_stamp());
        drive_item(OP_EOF, 6'd42, 12'h000, 12'h000, rand_stamp());
        // empty frames: lose everything, then LOST ages out
        drive_item(OP_EOF, 6'd0, 12'h000, 12'h000, rand_stamp());
        drive_item(OP_EOF, 6'd0, 12'h000, 12'h000, rand_stamp());
        drive_item(OP_DETECT, 6'd63, 12'habc, 12'hdef, rand_stamp());
        drive_item(OP_EOF, 6'd63, 12'h000, 12'h000, rand_stamp());
        drain_results();

        random_sent = 0;
        full_done   = 1'b0;
        last_id     = '0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                idle_on = 1'b0;
            end
            if (random_sent >= 10 && !full_done) begin
                // fill the whole table, then lose all of it in one sweep
                full_done = 1'b1;
                start = $urandom_range(0, ID_COUNT - 1);
                for (int k = 0; k < ID_COUNT; k++) begin
                    send_detection(ID_W'((start + k) % ID_COUNT));
                end
                send_eof();
                send_eof();
                random_sent += ID_COUNT + 2;
                foreach (prev_seen[i]) begin
                    prev_seen[i] = 1'b0;
                end
                drain_results();
            end else begin
                n_det = $urandom_range(0, 10);
                foreach (cur_seen[i]) begin
                    cur_seen[i] = 1'b0;
                end
                for (int k = 0; k < n_det; k++) begin
                    prefer_prev = ($urandom_range(0, 2) != 0);
                    id = ID_W'($urandom_range(0, ID_COUNT - 1));
                    tries = 0;
                    while (tries < 16 && ((prefer_prev && !prev_seen[id]) || cur_seen[id])) begin
                        id = ID_W'($urandom_range(0, ID_COUNT - 1));
                        tries++;
                    end
                    // occasionally break the one-ID-per-frame rule
                    if (k > 0 && $urandom_range(0, 11) == 0) begin
                        id = last_id;
                    end
                    send_detection(id);
                    cur_seen[id] = 1'b1;
                    last_id = id;
                end
                send_eof();
                random_sent += n_det + 1;
                prev_seen = cur_seen;
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (results_due == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.n_mismatch == 0 && results_due == 0) begin
            $display("[track_lifecycle_state_table_core] OK");
        end else begin
            $display("[track_lifecycle_state_table_core] ERROR");
        end
        $finish;
    end

endmodule
